/* src/booth_pkg.sv */
// Shared constants, types and control structs for the Booth radix-2 multiplier.
package booth_pkg;

   localparam int WIDTH    = 16;
   localparam int IN_W     = 16;
   localparam int PROD_W   = 32;
   localparam int CNT_W    = (WIDTH > 1) ? $clog2(WIDTH) : 1;
   localparam int REQ_DATA_W = 2 * IN_W;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_RUN,
      ST_WAIT
   } booth_state_type;

   typedef struct packed {
      logic load;
      logic step;
      logic emit;
   } booth_cmd_type;

   typedef struct packed {
      logic last_step;
   } booth_status_type;

endpackage

/* src/booth_ctrl.sv */
// Controller: sequences load, WIDTH Booth steps and the hand-off to the output register.
module booth_ctrl
   import booth_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             req_tvalid,
   output logic             req_tready,
   output logic             rsp_tvalid,
   input  logic             rsp_tready,
   input  booth_status_type status,
   output booth_cmd_type    cmd
);

   booth_state_type state_ff, state_in;
   logic            rsp_valid_ff, rsp_valid_in;
   logic            slot_free;

   // output register can take a new beat
   assign slot_free = !rsp_valid_ff || rsp_tready;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) state_in = ST_RUN;
         end
         ST_RUN: begin
            if (status.last_step) state_in = slot_free ? ST_IDLE : ST_WAIT;
         end
         ST_WAIT: begin
            if (slot_free) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      cmd        = '0;
      req_tready = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            cmd.load   = req_tvalid;
         end
         ST_RUN: begin
            cmd.step = 1'b1;
            cmd.emit = status.last_step && slot_free;
         end
         ST_WAIT: begin
            cmd.emit = slot_free;
         end
         default: begin
            cmd        = '0;
            req_tready = 1'b0;
         end
      endcase
   end

   always_comb begin
      if (cmd.emit) rsp_valid_in = 1'b1;
      else if (rsp_tready) rsp_valid_in = 1'b0;
      else rsp_valid_in = rsp_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;

endmodule

/* src/booth_dp.sv */
// Datapath: accumulator with guard bit, multiplier shift register, step counter, output register.
module booth_dp
   import booth_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  booth_cmd_type         cmd,
   input  logic [IN_W-1:0]       multiplicand,
   input  logic [IN_W-1:0]       multiplier,
   output booth_status_type      status,
   output logic [PROD_W-1:0]     product
);

   logic [WIDTH:0]    mcand_ff, mcand_in;
   logic [WIDTH:0]    acc_ff, acc_in;
   logic [WIDTH-1:0]  q_ff, q_in;
   logic              extra_ff, extra_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic [PROD_W-1:0] product_ff, product_in;
   logic [WIDTH:0]    sum;

   // Booth recode on {q0, extra}: 10 subtracts, 01 adds
   always_comb begin
      case ({q_ff[0], extra_ff})
         2'b10:   sum = acc_ff - mcand_ff;
         2'b01:   sum = acc_ff + mcand_ff;
         default: sum = acc_ff;
      endcase
   end

   always_comb begin
      mcand_in = mcand_ff;
      acc_in   = acc_ff;
      q_in     = q_ff;
      extra_in = extra_ff;
      count_in = count_ff;
      if (cmd.load) begin
         mcand_in = {multiplicand[WIDTH-1], multiplicand[WIDTH-1:0]};
         acc_in   = '0;
         q_in     = multiplier[WIDTH-1:0];
         extra_in = 1'b0;
         count_in = '0;
      end else if (cmd.step) begin
         acc_in   = {sum[WIDTH], sum[WIDTH:1]};
         q_in     = {sum[0], q_ff[WIDTH-1:1]};
         extra_in = q_ff[0];
         count_in = count_ff + CNT_W'(1);
      end
   end

   // on emit (on the last step, or later from WAIT) the result is taken straight from the next-state values
   assign product_in = cmd.emit ? PROD_W'({acc_in[WIDTH-1:0], q_in}) : product_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      mcand_ff   <= mcand_in;
      acc_ff     <= acc_in;
      q_ff       <= q_in;
      extra_ff   <= extra_in;
      product_ff <= product_in;
   end

   assign status.last_step = (count_ff == CNT_W'(WIDTH - 1));
   assign product          = product_ff;

endmodule

/* src/booth_radix2_multiplier_top.sv */
// Top level of the Booth radix-2 signed multiplier.
//
// Usage:
//   req channel: one beat carries a multiplicand and a multiplier, both signed
//   16-bit two's complement. rsp channel: one beat per request carrying the
//   signed 32-bit product.
//   The edge that takes the request beat loads the operands; WIDTH = 16 Booth
//   steps follow, one per edge, and rsp_tvalid rises on the edge of the last
//   step if the output register is free. The single add/subtract unit
//   retires one recoded multiplier bit per cycle, and req_tready is high only
//   while that unit is free, so a new request waits until the last step is done.
//   A finished product sits in the output register, so the next request is
//   taken while the previous product still waits on rsp_tready. If the receiver
//   still stalls when the following product is done, that product is held in
//   the accumulator until the output register empties, and no new request is
//   taken meanwhile.
//   Reset (synchronous, active high) returns the controller to idle and
//   drops rsp_tvalid; any product in flight is discarded.
module booth_radix2_multiplier_top
   import booth_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [REQ_DATA_W-1:0] req_tdata,   // [15:0] multiplicand, [31:16] multiplier
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [PROD_W-1:0]     rsp_tdata    // [31:0] product
);

   booth_cmd_type    cmd;
   booth_status_type status;

   booth_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .status     (status),
      .cmd        (cmd)
   );

   booth_dp u_dp (
      .clock        (clock),
      .reset        (reset),
      .cmd          (cmd),
      .multiplicand (req_tdata[IN_W-1:0]),
      .multiplier   (req_tdata[2*IN_W-1:IN_W]),
      .status       (status),
      .product      (rsp_tdata)
   );

endmodule

/* src/booth_chk.sv */
// Port-level checker for the Booth multiplier, bound to the top level.
module booth_chk
   import booth_pkg::*;
(
   input logic              clock,
   input logic              reset,
   input logic              req_tvalid,
   input logic              req_tready,
   input logic              rsp_tvalid,
   input logic              rsp_tready,
   input logic [PROD_W-1:0] rsp_tdata
);

   logic req_beat;
   assign req_beat = req_tvalid && req_tready;

   // a stalled result beat stays up
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid)
      else $error("rsp_tvalid dropped while stalled");

   // payload of a stalled beat does not change
   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> $stable(rsp_tdata))
      else $error("rsp_tdata changed while stalled");

   // the unit is busy straight after taking a request
   a_busy_start: assert property (@(posedge clock) disable iff (reset)
      req_beat |=> !req_tready)
      else $error("request taken while unit busy");

   // still busy on the final Booth step
   a_busy_end: assert property (@(posedge clock) disable iff (reset)
      req_beat |-> ##WIDTH !req_tready)
      else $error("unit freed before the last step");

   // no result beat straight out of reset
   a_reset_quiet: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("rsp_tvalid high after reset");

endmodule

bind booth_radix2_multiplier_top booth_chk u_booth_chk (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);
